// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion wrappers, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/tccs_pkg.sv -----
// ----------------------------------------------------------------------------
// tccs_pkg
// types and constants shared by the text console blocks
// ----------------------------------------------------------------------------
package tccs_pkg;

	localparam int MAX_ROWS_DEF = 32;
	localparam int MAX_COLS_DEF = 128;

	localparam int CHAR_W = 8;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

	localparam logic [5:0] ROWS_RESET = 6'd24;
	localparam logic [7:0] COLS_RESET = 8'd80;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef struct packed {
		logic       command;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} in_t;

	typedef struct packed {
		logic [7:0] read_char;
		logic [6:0] cursor_col_out;
		logic [4:0] cursor_row_out;
		logic       scrolled;
	} out_t;

	typedef enum logic [1:0] {
		OP_READ,
		OP_PUT,
		OP_NEWLINE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_col;
		logic       in_range;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_COPY,
		ST_FILL
	} state_t;

endpackage

// ----- hw/rtl/tccs_ram.sv -----
// ----------------------------------------------------------------------------
// tccs_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module tccs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/tccs_front.sv -----
// ----------------------------------------------------------------------------
// tccs_front
// takes command words, classifies them and hands them to the queue
// ----------------------------------------------------------------------------
module tccs_front #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  tccs_pkg::in_t   item,
	input  logic            clearing,
	input  logic            q_ready,
	output logic            busy,
	output logic            push,
	output tccs_pkg::entry_t push_entry
);
	import tccs_pkg::*;

	logic   valid_s1;
	entry_t ent_s1;
	entry_t ent_d;
	logic   accept;

	assign push   = valid_s1 && q_ready;
	assign busy   = clearing || (valid_s1 && !q_ready);
	assign accept = start && !busy;

	always_comb begin
		ent_d.char_code = item.char_code;
		ent_d.read_row  = item.read_row;
		ent_d.read_col  = item.read_col;
		ent_d.in_range  = (32'(item.read_row) < MAX_ROWS) && (32'(item.read_col) < MAX_COLS);
		if (item.command) begin
			ent_d.op = OP_READ;
		end else if (item.char_code == CH_NEWLINE) begin
			ent_d.op = OP_NEWLINE;
		end else begin
			ent_d.op = OP_PUT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_s1 <= ent_d;
		end
	end

	assign push_entry = ent_s1;

endmodule

// ----- hw/rtl/tccs_queue.sv -----
// ----------------------------------------------------------------------------
// tccs_queue
// short fifo of classified commands between front and back
// ----------------------------------------------------------------------------
module tccs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tccs_pkg::entry_t push_entry,
	output logic             q_ready,
	input  logic             pop,
	output logic             q_valid,
	output tccs_pkg::entry_t q_entry
);
	import tccs_pkg::*;

	entry_t            slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign q_ready = count_q != QCNT_W'(QDEPTH);
	assign q_valid = count_q != '0;
	assign do_push = push && q_ready;
	assign do_pop  = pop && q_valid;
	assign q_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ----- hw/rtl/tccs_back.sv -----
// ----------------------------------------------------------------------------
// tccs_back
// executes queued commands: cell reads and writes, cursor, scroll, clear pass
// ----------------------------------------------------------------------------
module tccs_back #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 128
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	input  tccs_pkg::entry_t                   q_entry,
	output logic                               pop,
	input  logic [$clog2(MAX_ROWS+1)-1:0]      eff_rows,
	input  logic [$clog2(MAX_COLS+1)-1:0]      eff_cols,
	input  logic                               clamp,
	output logic                               clearing,
	output logic                               done,
	output tccs_pkg::out_t                     result
);
	import tccs_pkg::*;

	localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int RCNT_W = $clog2(MAX_ROWS + 1);
	localparam int CCNT_W = $clog2(MAX_COLS + 1);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int DEPTH  = 1 << ADDR_W;

	state_t             state_q, state_d;
	logic [ROW_W-1:0]   cur_row_q, cur_row_d;
	logic [COL_W-1:0]   cur_col_q, cur_col_d;
	logic [ROW_W-1:0]   sc_row_q, sc_row_d;
	logic [COL_W-1:0]   sc_col_q, sc_col_d;
	logic [ADDR_W-1:0]  clr_q, clr_d;
	logic               pend_s1, pend_d;
	logic [ADDR_W-1:0]  wr_addr_s1, wr_addr_d;
	logic               inrange_q, inrange_d;
	logic               done_q, done_d;
	out_t               res_q, res_d;

	logic               we;
	logic [ADDR_W-1:0]  waddr;
	logic [CHAR_W-1:0]  wdata;
	logic [ADDR_W-1:0]  raddr;
	logic [CHAR_W-1:0]  rdata;

	logic [COL_W-1:0]   last_col;
	logic [ROW_W-1:0]   last_row;
	logic [ROW_W-1:0]   last_copy_row;
	logic [CCNT_W-1:0]  col_inc;
	logic [RCNT_W-1:0]  row_inc;
	logic               next_line;

	tccs_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign last_col      = COL_W'(eff_cols - CCNT_W'(1));
	assign last_row      = ROW_W'(eff_rows - RCNT_W'(1));
	assign last_copy_row = ROW_W'(eff_rows - RCNT_W'(2));
	assign col_inc       = CCNT_W'(cur_col_q) + CCNT_W'(1);
	assign row_inc       = RCNT_W'(cur_row_q) + RCNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		we        = 1'b0;
		waddr     = wr_addr_s1;
		wdata     = CH_SPACE;
		raddr     = '0;
		cur_row_d = cur_row_q;
		cur_col_d = cur_col_q;
		sc_row_d  = sc_row_q;
		sc_col_d  = sc_col_q;
		clr_d     = clr_q;
		pend_d    = pend_s1;
		wr_addr_d = wr_addr_s1;
		inrange_d = inrange_q;
		done_d    = 1'b0;
		res_d     = res_q;
		next_line = 1'b0;

		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				clr_d = clr_q + ADDR_W'(1);
				if (clr_q == {ADDR_W{1'b1}}) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					case (q_entry.op)
						OP_READ: begin
							raddr     = {ROW_W'(q_entry.read_row), COL_W'(q_entry.read_col)};
							inrange_d = q_entry.in_range;
							state_d   = ST_RD;
						end
						OP_PUT, OP_NEWLINE: begin
							if (q_entry.op == OP_PUT) begin
								we        = 1'b1;
								waddr     = {cur_row_q, cur_col_q};
								wdata     = q_entry.char_code;
								next_line = col_inc >= eff_cols;
							end else begin
								next_line = 1'b1;
							end
							res_d.read_char = '0;
							res_d.scrolled  = 1'b0;
							if (!next_line) begin
								cur_col_d            = COL_W'(col_inc);
								res_d.cursor_col_out = 7'(col_inc);
								res_d.cursor_row_out = 5'(cur_row_q);
								done_d               = 1'b1;
							end else if (row_inc < eff_rows) begin
								cur_col_d            = '0;
								cur_row_d            = ROW_W'(row_inc);
								res_d.cursor_col_out = '0;
								res_d.cursor_row_out = 5'(row_inc);
								done_d               = 1'b1;
							end else begin
								// past the last row: scroll, result follows at the end
								cur_col_d = '0;
								cur_row_d = last_row;
								sc_row_d  = '0;
								sc_col_d  = '0;
								pend_d    = 1'b0;
								state_d   = (eff_rows > RCNT_W'(1)) ? ST_COPY : ST_FILL;
							end
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			ST_RD: begin
				res_d.read_char      = inrange_q ? rdata : '0;
				res_d.cursor_col_out = 7'(cur_col_q);
				res_d.cursor_row_out = 5'(cur_row_q);
				res_d.scrolled       = 1'b0;
				done_d               = 1'b1;
				state_d              = ST_IDLE;
			end
			ST_COPY: begin
				// read one row below, write it back in the following cycle
				raddr     = {ROW_W'(sc_row_q + ROW_W'(1)), sc_col_q};
				pend_d    = 1'b1;
				wr_addr_d = {sc_row_q, sc_col_q};
				if (pend_s1) begin
					we    = 1'b1;
					waddr = wr_addr_s1;
					wdata = rdata;
				end
				if (sc_col_q == last_col) begin
					sc_col_d = '0;
					if (sc_row_q == last_copy_row) begin
						state_d = ST_FILL;
					end else begin
						sc_row_d = sc_row_q + ROW_W'(1);
					end
				end else begin
					sc_col_d = sc_col_q + COL_W'(1);
				end
			end
			ST_FILL: begin
				we = 1'b1;
				if (pend_s1) begin
					// drain the last copied cell first
					waddr  = wr_addr_s1;
					wdata  = rdata;
					pend_d = 1'b0;
				end else begin
					waddr = {last_row, sc_col_q};
					wdata = CH_SPACE;
					if (sc_col_q == last_col) begin
						res_d.read_char      = '0;
						res_d.cursor_col_out = 7'(cur_col_q);
						res_d.cursor_row_out = 5'(cur_row_q);
						res_d.scrolled       = 1'b1;
						done_d               = 1'b1;
						state_d              = ST_IDLE;
					end else begin
						sc_col_d = sc_col_q + COL_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// window resized: pull the cursor inside
		if (clamp) begin
			if (RCNT_W'(cur_row_q) >= eff_rows) begin
				cur_row_d = last_row;
			end
			if (CCNT_W'(cur_col_q) >= eff_cols) begin
				cur_col_d = last_col;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
			clr_q     <= '0;
			pend_s1   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			cur_row_q <= cur_row_d;
			cur_col_q <= cur_col_d;
			clr_q     <= clr_d;
			pend_s1   <= pend_d;
			done_q    <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		sc_row_q   <= sc_row_d;
		sc_col_q   <= sc_col_d;
		wr_addr_s1 <= wr_addr_d;
		inrange_q  <= inrange_d;
		res_q      <= res_d;
	end

	assign clearing = state_q == ST_CLEAR;
	assign done     = done_q;
	assign result   = res_q;

endmodule

// ----- hw/rtl/text_console_cursor_scroll.sv -----
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// text window console with cursor, line wrap and scroll
// ----------------------------------------------------------------------------
// channel   signals                               transfer
// command   start, busy, item                     start high and busy low
// result    done, result                          done high, one cycle
// config    cfg_valid, cfg_ready, cfg_index/data  cfg_valid and cfg_ready
//
// writes and newlines end in ST_IDLE, reads go on to ST_RD (registered read);
// a word is registered in the front and reaches the back end via the queue.
// a scroll moves rows 1..rows-1 up one row and fills the last row with spaces
// (only the fill for a one-row window), one store cell per cycle.
// after reset the store (2^(row+col bits) cells, 4096 by default) is cleared to
// spaces with busy high; config writes are taken throughout. results cannot be
// held off; busy is high while clearing or while a word waits on a full queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_cursor_scroll #(
	parameter int MAX_ROWS = tccs_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = tccs_pkg::MAX_COLS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  tccs_pkg::in_t                       item,
	output logic                                done,
	output tccs_pkg::out_t                      result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tccs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tccs_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import tccs_pkg::*;

	localparam int RCNT_W = $clog2(MAX_ROWS + 1);
	localparam int CCNT_W = $clog2(MAX_COLS + 1);

	logic [5:0]        rows_q;
	logic [7:0]        cols_q;
	logic              clamp_q;
	logic [RCNT_W-1:0] eff_rows;
	logic [CCNT_W-1:0] eff_cols;

	logic              clearing;
	logic              q_ready;
	logic              push;
	entry_t            push_entry;
	logic              pop;
	logic              q_valid;
	entry_t            q_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= ROWS_RESET;
			cols_q  <= COLS_RESET;
			clamp_q <= 1'b0;
		end else begin
			clamp_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ROWS: begin
						rows_q  <= cfg_data[5:0];
						clamp_q <= 1'b1;
					end
					REG_COLS: begin
						cols_q  <= cfg_data;
						clamp_q <= 1'b1;
					end
					default: begin
						clamp_q <= 1'b0;
					end
				endcase
			end
		end
	end

	// zero counts as one, anything past the store counts as its size
	always_comb begin
		if (rows_q == '0) begin
			eff_rows = RCNT_W'(1);
		end else if (32'(rows_q) > MAX_ROWS) begin
			eff_rows = RCNT_W'(MAX_ROWS);
		end else begin
			eff_rows = RCNT_W'(rows_q);
		end
		if (cols_q == '0) begin
			eff_cols = CCNT_W'(1);
		end else if (32'(cols_q) > MAX_COLS) begin
			eff_cols = CCNT_W'(MAX_COLS);
		end else begin
			eff_cols = CCNT_W'(cols_q);
		end
	end

	tccs_front #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.clearing  (clearing),
		.q_ready   (q_ready),
		.busy      (busy),
		.push      (push),
		.push_entry(push_entry)
	);

	tccs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.q_ready   (q_ready),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_entry   (q_entry)
	);

	tccs_back #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.pop     (pop),
		.eff_rows(eff_rows),
		.eff_cols(eff_cols),
		.clamp   (clamp_q),
		.clearing(clearing),
		.done    (done),
		.result  (result)
	);

	`ASSERT_IMPLY(a_busy_while_clearing, clearing, busy, "word taken during clear pass")
	`ASSERT_IMPLY(a_row_in_window, done, 32'(result.cursor_row_out) < 32'(eff_rows),
		"cursor row outside window")
	`ASSERT_IMPLY(a_col_in_window, done, 32'(result.cursor_col_out) < 32'(eff_cols),
		"cursor column outside window")
	`ASSERT_IMPLY(a_scroll_col_zero, done && result.scrolled, result.cursor_col_out == '0,
		"scroll left cursor off column zero")

endmodule
